/* design/array_insert_delete_shifter_core_defines.svh */
// Assertion macros for the array insert/delete shifter.
`ifndef ARRAY_INSERT_DELETE_SHIFTER_CORE_DEFINES_SVH
`define ARRAY_INSERT_DELETE_SHIFTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, clocked on clk, masked during reset.
`define AIDS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked property, clocked on clk, also active during reset.
`define AIDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AIDS_ASSERT(lbl, prop, msg)
`define AIDS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* design/aids_pkg.sv */
// Shared types and codes for the array insert/delete shifter.
`timescale 1ns / 1ps
package aids_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int CNT_W  = 6;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_DELETE = 2'd3
    } cell_op_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   pos;
    } cell_ctrl_t;

endpackage

/* design/aids_cell.sv */
// One storage cell of the shifting row.
`timescale 1ns / 1ps
module aids_cell
    import aids_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int OCC_W = 6
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic [OCC_W-1:0]         occ,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] left,
    input  logic signed [DATA_W-1:0] right,
    output logic signed [DATA_W-1:0] q
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_APPEND:
            begin
                if (32'(occ) == 32'(IDX))
                begin
                    data_next = value;
                end
            end
            CELL_INSERT:
            begin
                if (32'(ctrl.pos) == 32'(IDX))
                begin
                    data_next = value;
                end
                else if (32'(ctrl.pos) < 32'(IDX))
                begin
                    data_next = left;   // move up
                end
            end
            CELL_DELETE:
            begin
                if (32'(ctrl.pos) <= 32'(IDX))
                begin
                    data_next = right;  // move down, zero enters at the top
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

/* design/aids_ctrl.sv */
// Command decode, occupancy count and result register.
`timescale 1ns / 1ps
module aids_ctrl
    import aids_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int OCC_W    = 6
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  cmd_t                     cmd,
    input  logic [POS_W-1:0]         pos,
    input  logic signed [DATA_W-1:0] rd_data,
    output cell_ctrl_t               cell_ctrl,
    output logic [OCC_W-1:0]         occ,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_read_value,
    output status_t                  out_status,
    output logic [CNT_W-1:0]         out_count
);

    localparam int CW = (OCC_W > POS_W) ? OCC_W : POS_W;

    logic                     fire;
    logic                     full;
    logic [CW-1:0]            pos_w;
    logic [CW-1:0]            occ_w;
    cell_op_t                 op;

    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;
    logic                     valid_reg;
    logic signed [DATA_W-1:0] rd_reg;
    logic signed [DATA_W-1:0] rd_next;
    status_t                  st_reg;
    status_t                  st_next;
    logic [CNT_W-1:0]         cnt_reg;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign full     = (occ_reg == OCC_W'(CAPACITY));
    assign pos_w    = CW'(pos);
    assign occ_w    = CW'(occ_reg);

    always_comb
    begin
        op       = CELL_HOLD;
        st_next  = ST_OK;
        rd_next  = '0;
        occ_next = occ_reg;
        unique case (cmd)
            CMD_APPEND:
            begin
                if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    op       = CELL_APPEND;
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            CMD_INSERT:
            begin
                priority if (pos_w > occ_w)
                begin
                    st_next = ST_RANGE;
                end
                else if (full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    op       = CELL_INSERT;
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            CMD_DELETE:
            begin
                if (pos_w >= occ_w)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    op       = CELL_DELETE;
                    occ_next = occ_reg - OCC_W'(1);
                end
            end
            CMD_READ:
            begin
                if (pos_w >= occ_w)
                begin
                    st_next = ST_RANGE;
                end
                else
                begin
                    rd_next = rd_data;
                end
            end
            default:
            begin
                st_next = ST_RANGE;
            end
        endcase
    end

    assign cell_ctrl.op  = fire ? op : CELL_HOLD;
    assign cell_ctrl.pos = pos;
    assign occ           = occ_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                occ_reg   <= occ_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rd_reg  <= rd_next;
            st_reg  <= st_next;
            cnt_reg <= CNT_W'(occ_next);
        end
    end

    assign out_valid      = valid_reg;
    assign out_read_value = rd_reg;
    assign out_status     = st_reg;
    assign out_count      = cnt_reg;

endmodule

/* design/array_insert_delete_shifter_core.sv */
// Top level of the array insert/delete shifter: cell row, read select and control.
`timescale 1ns / 1ps
// Store of up to CAPACITY signed 32-bit entries kept packed from slot 0, with
// an occupancy count. Each input word carries one command (append, insert at a
// position, delete at a position, read at a position) and gives exactly one
// result word with a status (ok, out of range, full), the read value (zero
// unless a read succeeds) and the count after the command. One word is taken
// every clock: the whole row of cells moves up, moves down or holds in the
// same cycle, so each command completes on acceptance and its result lands
// in the output register in the cycle after acceptance. The output register
// gates the rate: a new word is taken whenever it is empty or being drained
// in that cycle. Positions reach 31 only, so insert, delete and read address
// the first 32 slots; append can fill a larger store. The count field carries
// the occupancy modulo 64. All cells clear at reset, no clearing pass is needed.
`include "array_insert_delete_shifter_core_defines.svh"
module array_insert_delete_shifter_core
    import aids_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [4:0] position, [36:5] value, [39:37] zero
    input  logic [1:0]  s_tuser,    // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [31:0] read_value, [37:32] count, [39:38] zero
    output logic [1:0]  m_tuser     // [1:0] status
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int RD_N  = (CAPACITY < 32) ? CAPACITY : 32;

    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    cmd_t                     cmd;
    cell_ctrl_t               cell_ctrl;
    logic [OCC_W-1:0]         occ;
    logic signed [DATA_W-1:0] cell_q [CAPACITY];
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] out_read_value;
    status_t                  out_status;
    logic [CNT_W-1:0]         out_count;

    assign pos   = s_tdata[4:0];
    assign value = s_tdata[36:5];
    assign cmd   = cmd_t'(s_tuser);

    // Row of cells; each sees its neighbours for the shift up or down.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[i+1];
        end

        aids_cell #(
            .IDX   (i),
            .OCC_W (OCC_W)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl),
            .occ   (occ),
            .value (value),
            .left  (left_d),
            .right (right_d),
            .q     (cell_q[i])
        );
    end

    // Read select over the addressable slots.
    always_comb
    begin
        rd_data = '0;
        for (int j = 0; j < RD_N; j++)
        begin
            if (pos == POS_W'(j))
            begin
                rd_data = cell_q[j];
            end
        end
    end

    aids_ctrl #(
        .CAPACITY (CAPACITY),
        .OCC_W    (OCC_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .cmd            (cmd),
        .pos            (pos),
        .rd_data        (rd_data),
        .cell_ctrl      (cell_ctrl),
        .occ            (occ),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_read_value (out_read_value),
        .out_status     (out_status),
        .out_count      (out_count)
    );

    assign m_tdata = {2'b00, out_count, out_read_value};
    assign m_tuser = out_status;

    // Occupancy never passes the capacity; trivially true while reset is held.
    `AIDS_ASSERT_ALWAYS(a_occ_bound, !rst_n || 32'(occ) <= 32'(CAPACITY), "occupancy above capacity")
    // A full status is only given when the store is at capacity.
    `AIDS_ASSERT(a_full_status, m_tvalid && (out_status == ST_FULL) |-> 32'(occ) == 32'(CAPACITY), "full status below capacity")
    // A failed command never returns data.
    `AIDS_ASSERT(a_fail_zero, m_tvalid && (out_status != ST_OK) |-> out_read_value == '0, "data on failed command")
    // Every accepted word leaves a result waiting next cycle.
    `AIDS_ASSERT(a_result, s_tvalid && s_tready |=> m_tvalid, "accepted word lost")

endmodule
